FILE: rtl/core/alfx_pkg.sv
`default_nettype none
package alfx_pkg;

  // Line store geometry
  localparam int LINE_CAPACITY = 256;
  localparam int ADDR_W = $clog2(LINE_CAPACITY);
  localparam int CNT_W = ADDR_W + 1;

  // Field widths and limits
  localparam int DATA_W = 8;
  localparam int LEN_W = 9;
  localparam int VAL_W = 9;
  localparam int CMD_LIMIT = 256;
  localparam int VALUE_MAX = 255;

  // Character codes
  localparam logic [DATA_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [DATA_W-1:0] CHAR_BANG  = 8'h21;
  localparam logic [DATA_W-1:0] CHAR_SEMI  = 8'h3B;
  localparam logic [DATA_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [DATA_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [DATA_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [DATA_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [DATA_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [DATA_W-1:0] CHAR_VT    = 8'h0B;
  localparam logic [DATA_W-1:0] CHAR_FF    = 8'h0C;

  typedef enum logic [1:0] {
    STATUS_PLAIN = 2'd0,
    STATUS_GOOD  = 2'd1,
    STATUS_BAD   = 2'd2
  } line_status_t;

  typedef enum logic [1:0] {
    PHASE_BLANKS = 2'd0,
    PHASE_SIGN   = 2'd1,
    PHASE_DIGITS = 2'd2,
    PHASE_DONE   = 2'd3
  } number_phase_t;

  // Result descriptor from the parser; first char comes from the store
  typedef struct packed {
    line_status_t              status;
    logic [LEN_W-1:0]          length;
    logic                      use_first;
    logic [DATA_W-1:0]         checksum;
  } result_req_t;

  // Occupancy of the result stages
  typedef struct packed {
    logic hold_valid;
    logic out_valid;
  } stage_state_t;

  function automatic logic is_terminator(input logic [DATA_W-1:0] c);
    return (c == CHAR_CR) || (c == CHAR_LF) || (c == CHAR_BANG);
  endfunction

  function automatic logic is_blank(input logic [DATA_W-1:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
  endfunction

  function automatic logic is_digit(input logic [DATA_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Length capped at the command limit
  function automatic logic [LEN_W-1:0] cap_length(input logic [CNT_W-1:0] n);
    logic [31:0] v;
    v = 32'(n);
    if (v > 32'(CMD_LIMIT)) v = 32'(CMD_LIMIT);
    return v[LEN_W-1:0];
  endfunction

  // Length taken modulo the field width
  function automatic logic [LEN_W-1:0] fit_length(input logic [CNT_W-1:0] n);
    logic [31:0] v;
    v = 32'(n);
    return v[LEN_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/alfx_if.sv
`default_nettype none
// Byte stream channel
interface alfx_byte_if;
  logic                           valid;
  logic                           ready;
  logic [alfx_pkg::DATA_W-1:0]    data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// Line result channel
interface alfx_result_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     line_status;
  logic [alfx_pkg::LEN_W-1:0]     command_length;
  logic [alfx_pkg::DATA_W-1:0]    first_char;
  logic [alfx_pkg::DATA_W-1:0]    computed_checksum;

  modport source (output valid, output line_status, output command_length,
                  output first_char, output computed_checksum, input ready);
  modport sink (input valid, input line_status, input command_length,
                input first_char, input computed_checksum, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ascii_line_framer_xor_checksum_unit.sv
`default_nettype none
// A line result goes from its terminator into the hold stage, then the output register.
// Throughput: one byte per cycle; the input stalls only while the hold stage and the
// output register are both full and the sink is not ready. The single store read of
// entry 0 per line is kept in the store's read register while its request waits in a
// hold stage ahead of the output register. Reset: synchronous rst clears the line
// state and both result stages; the line store is not cleared and needs no clearing pass.
module ascii_line_framer_xor_checksum_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  alfx_byte_if.sink         byte_in,
  alfx_result_if.source     line_out
);

  logic                              in_fire;
  logic                              accept_ok;
  logic                              ram_we;
  logic [alfx_pkg::ADDR_W-1:0]       ram_waddr;
  logic [alfx_pkg::DATA_W-1:0]       ram_wdata;
  logic                              ram_re;
  logic [alfx_pkg::DATA_W-1:0]       ram_rdata;
  logic                              req_valid;
  alfx_pkg::result_req_t             req;
  alfx_pkg::stage_state_t            stage;

  assign byte_in.ready = accept_ok;
  assign in_fire       = byte_in.valid && accept_ok;

  // Per-line parser and checksum tracking
  alfx_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .data_byte (byte_in.data_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .req_valid (req_valid),
    .req       (req)
  );

  // Line store
  alfx_ram #(
    .WIDTH (alfx_pkg::DATA_W),
    .DEPTH (alfx_pkg::LINE_CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr ('0),
    .rdata (ram_rdata)
  );

  // Result staging
  alfx_result u_result (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req_valid),
    .req               (req),
    .ram_rdata         (ram_rdata),
    .out_ready         (line_out.ready),
    .out_valid         (line_out.valid),
    .line_status       (line_out.line_status),
    .command_length    (line_out.command_length),
    .first_char        (line_out.first_char),
    .computed_checksum (line_out.computed_checksum),
    .accept_ok         (accept_ok),
    .stage             (stage)
  );

`ifndef NO_ASSERTIONS
  // Input stalls only when both result stages are occupied
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !byte_in.ready |-> (stage.hold_valid && stage.out_valid))
    else $error("input stalled with a free result stage");

  // While a result is held, the output register is full in the next cycle
  a_hold_drains: assert property (@(posedge clk) disable iff (rst)
    stage.hold_valid |=> stage.out_valid)
    else $error("held result lost");

  // Rejected lines carry no command text
  a_bad_empty: assert property (@(posedge clk) disable iff (rst)
    (line_out.valid && line_out.line_status == alfx_pkg::STATUS_BAD) |->
    (line_out.command_length == '0 && line_out.first_char == '0))
    else $error("rejected line with command text");

  // Empty command text has no first char
  a_empty_first: assert property (@(posedge clk) disable iff (rst)
    (line_out.valid && line_out.command_length == '0) |-> (line_out.first_char == '0))
    else $error("first char on empty command");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/alfx_ram.sv
`default_nettype none
module alfx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output      logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/alfx_parser.sv
`default_nettype none
module alfx_parser (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_fire,
  input  wire logic [alfx_pkg::DATA_W-1:0]         data_byte,
  output      logic                                ram_we,
  output      logic [alfx_pkg::ADDR_W-1:0]         ram_waddr,
  output      logic [alfx_pkg::DATA_W-1:0]         ram_wdata,
  output      logic                                ram_re,
  output      logic                                req_valid,
  output      alfx_pkg::result_req_t               req
);

  logic [alfx_pkg::CNT_W-1:0]     write_index;
  logic                           reading_active;
  logic [alfx_pkg::DATA_W-1:0]    xor_acc;
  logic                           comment_seen;
  logic [alfx_pkg::CNT_W-1:0]     star_position;
  logic                           star_seen;
  logic                           bytes_after_star;
  alfx_pkg::number_phase_t        number_phase;
  alfx_pkg::number_phase_t        number_phase_next;
  logic [alfx_pkg::VAL_W-1:0]     received_value;
  logic [alfx_pkg::VAL_W-1:0]     received_value_next;
  logic                           value_overflow;
  logic                           value_overflow_next;
  logic [alfx_pkg::CNT_W-1:0]     pruned_len;

  logic                           term;
  logic                           at_cap;
  logic                           line_live;
  logic                           store_byte;
  logic                           c_digit;
  logic                           c_blank;
  logic [3:0]                     digit_val;
  logic [12:0]                    scaled;
  logic                           checksum_ok;
  logic [alfx_pkg::CNT_W-1:0]     index_inc;

  // Byte classification
  assign term       = alfx_pkg::is_terminator(data_byte);
  assign c_digit    = alfx_pkg::is_digit(data_byte);
  assign c_blank    = alfx_pkg::is_blank(data_byte);
  assign digit_val  = 4'(data_byte - alfx_pkg::CHAR_ZERO);
  assign at_cap     = (write_index == alfx_pkg::CNT_W'(alfx_pkg::LINE_CAPACITY));
  assign line_live  = reading_active && !at_cap;
  assign store_byte = in_fire && !term && line_live;
  assign index_inc  = write_index + alfx_pkg::CNT_W'(1);

  // value * 10 + digit
  assign scaled = {received_value, 3'b000} + {2'b00, received_value, 1'b0} + 13'(digit_val);

  // Store port
  assign ram_we    = store_byte;
  assign ram_waddr = write_index[alfx_pkg::ADDR_W-1:0];
  assign ram_wdata = data_byte;

  // Checksum number phase: next state
  always_comb begin
    number_phase_next = number_phase;
    case (number_phase)
      alfx_pkg::PHASE_BLANKS: begin
        if (c_blank) begin
          number_phase_next = alfx_pkg::PHASE_BLANKS;
        end else if (data_byte == alfx_pkg::CHAR_PLUS) begin
          number_phase_next = alfx_pkg::PHASE_SIGN;
        end else if (c_digit) begin
          number_phase_next = alfx_pkg::PHASE_DIGITS;
        end else begin
          number_phase_next = alfx_pkg::PHASE_DONE;
        end
      end
      alfx_pkg::PHASE_SIGN: begin
        number_phase_next = c_digit ? alfx_pkg::PHASE_DIGITS : alfx_pkg::PHASE_DONE;
      end
      alfx_pkg::PHASE_DIGITS: begin
        number_phase_next = c_digit ? alfx_pkg::PHASE_DIGITS : alfx_pkg::PHASE_DONE;
      end
      alfx_pkg::PHASE_DONE: begin
        number_phase_next = alfx_pkg::PHASE_DONE;
      end
      default: begin
        number_phase_next = number_phase;
      end
    endcase
  end

  // Checksum number phase: value and malformed flag
  always_comb begin
    received_value_next = received_value;
    value_overflow_next = value_overflow;
    case (number_phase)
      alfx_pkg::PHASE_BLANKS: begin
        if (c_digit) begin
          received_value_next = alfx_pkg::VAL_W'(digit_val);
        end else if (!c_blank && data_byte != alfx_pkg::CHAR_PLUS) begin
          value_overflow_next = 1'b1;
        end
      end
      alfx_pkg::PHASE_SIGN: begin
        if (c_digit) begin
          received_value_next = alfx_pkg::VAL_W'(digit_val);
        end else begin
          value_overflow_next = 1'b1;
        end
      end
      alfx_pkg::PHASE_DIGITS: begin
        if (c_digit) begin
          if (scaled > 13'(alfx_pkg::VALUE_MAX)) begin
            value_overflow_next = 1'b1;
            received_value_next = alfx_pkg::VAL_W'(alfx_pkg::VALUE_MAX + 1);
          end else begin
            received_value_next = scaled[alfx_pkg::VAL_W-1:0];
          end
        end
      end
      default: begin
        received_value_next = received_value;
      end
    endcase
  end

  // Line state update
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index      <= '0;
      reading_active   <= 1'b1;
      xor_acc          <= '0;
      comment_seen     <= 1'b0;
      star_position    <= '0;
      star_seen        <= 1'b0;
      bytes_after_star <= 1'b0;
      number_phase     <= alfx_pkg::PHASE_BLANKS;
      received_value   <= '0;
      value_overflow   <= 1'b0;
      pruned_len       <= '0;
    end else if (in_fire) begin
      if (term) begin
        write_index      <= '0;
        reading_active   <= 1'b1;
        xor_acc          <= '0;
        comment_seen     <= 1'b0;
        star_position    <= '0;
        star_seen        <= 1'b0;
        bytes_after_star <= 1'b0;
        number_phase     <= alfx_pkg::PHASE_BLANKS;
        received_value   <= '0;
        value_overflow   <= 1'b0;
        pruned_len       <= '0;
      end else if (at_cap) begin
        // overlong line: drop up to the next terminator
        reading_active <= 1'b0;
        write_index    <= '0;
      end else if (reading_active) begin
        write_index <= index_inc;
        if (!comment_seen) begin
          if (data_byte == alfx_pkg::CHAR_SEMI) begin
            comment_seen <= 1'b1;
          end else begin
            pruned_len <= index_inc;
            if (!star_seen) begin
              if (data_byte == alfx_pkg::CHAR_STAR) begin
                star_seen     <= 1'b1;
                star_position <= write_index;
              end else begin
                xor_acc <= xor_acc ^ data_byte;
              end
            end else begin
              bytes_after_star <= 1'b1;
              if (32'(write_index) < 32'(alfx_pkg::CMD_LIMIT)) begin
                number_phase   <= number_phase_next;
                received_value <= received_value_next;
                value_overflow <= value_overflow_next;
              end
            end
          end
        end
      end
    end
  end

  // Result at a terminator; entry 0 is read for the first char
  assign checksum_ok = (number_phase == alfx_pkg::PHASE_DIGITS ||
                        number_phase == alfx_pkg::PHASE_DONE) &&
                       !value_overflow &&
                       (received_value == {1'b0, xor_acc});
  assign req_valid = in_fire && term && line_live;
  assign ram_re    = req_valid;

  always_comb begin
    req.checksum = xor_acc;
    if (star_seen && bytes_after_star) begin
      if (checksum_ok) begin
        req.status    = alfx_pkg::STATUS_GOOD;
        req.length    = alfx_pkg::fit_length(star_position);
        req.use_first = (star_position != '0);
      end else begin
        req.status    = alfx_pkg::STATUS_BAD;
        req.length    = '0;
        req.use_first = 1'b0;
      end
    end else begin
      req.status    = alfx_pkg::STATUS_PLAIN;
      req.length    = alfx_pkg::cap_length(pruned_len);
      req.use_first = (pruned_len != '0);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/alfx_result.sv
`default_nettype none
module alfx_result (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                req_valid,
  input  wire alfx_pkg::result_req_t               req,
  input  wire logic [alfx_pkg::DATA_W-1:0]         ram_rdata,
  input  wire logic                                out_ready,
  output      logic                                out_valid,
  output      logic [1:0]                          line_status,
  output      logic [alfx_pkg::LEN_W-1:0]          command_length,
  output      logic [alfx_pkg::DATA_W-1:0]         first_char,
  output      logic [alfx_pkg::DATA_W-1:0]         computed_checksum,
  output      logic                                accept_ok,
  output      alfx_pkg::stage_state_t              stage
);

  logic                      hold_valid;
  alfx_pkg::result_req_t     hold_req;
  logic                      hold_move;

  // Hold stage waits on the store read; output register faces the sink
  assign hold_move = hold_valid && (!out_valid || out_ready);
  assign accept_ok = !hold_valid || !out_valid || out_ready;

  assign stage.hold_valid = hold_valid;
  assign stage.out_valid  = out_valid;

  // Stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (req_valid) begin
        hold_valid <= 1'b1;
      end else if (hold_move) begin
        hold_valid <= 1'b0;
      end
      if (hold_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (req_valid) begin
      hold_req <= req;
    end
    if (hold_move) begin
      line_status       <= hold_req.status;
      command_length    <= hold_req.length;
      first_char        <= hold_req.use_first ? ram_rdata : '0;
      computed_checksum <= hold_req.checksum;
    end
  end

endmodule
`default_nettype wire

FILE: sim/ascii_line_framer_xor_checksum_unit_tb.sv
`timescale 1ns / 100ps
module ascii_line_framer_xor_checksum_unit_tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_IDLE     = 5;
  localparam int unsigned RANDOM_BYTES = 80;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam logic [alfx_pkg::DATA_W-1:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    alfx_pkg::line_status_t          status;
    logic [alfx_pkg::LEN_W-1:0]      length;
    logic [alfx_pkg::DATA_W-1:0]     first_char;
    logic [alfx_pkg::DATA_W-1:0]     checksum;
  } line_result_t;

  typedef enum int {
    LINE_PLAIN,
    LINE_GOOD_SUM,
    LINE_BAD_SUM,
    LINE_MALFORMED,
    LINE_NOISE
  } line_kind_t;

  logic clk = 1'b0;
  logic rst;

  alfx_byte_if   byte_ch ();
  alfx_result_if line_ch ();

  ascii_line_framer_xor_checksum_unit dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_ch),
    .line_out (line_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Line framer state, mirrored for prediction
  logic [alfx_pkg::CNT_W-1:0]  fr_index;
  logic                        fr_live;
  logic [alfx_pkg::DATA_W-1:0] fr_xor;
  logic                        fr_comment;
  logic [alfx_pkg::CNT_W-1:0]  fr_star_at;
  logic                        fr_star;
  logic                        fr_after_star;
  alfx_pkg::number_phase_t     fr_phase;
  logic [alfx_pkg::VAL_W-1:0]  fr_value;
  logic                        fr_bad_number;
  logic [alfx_pkg::CNT_W-1:0]  fr_text_len;
  logic [alfx_pkg::DATA_W-1:0] fr_head;

  line_result_t                expected_lines[$];
  logic [alfx_pkg::DATA_W-1:0] staged[$];

  int unsigned bytes_sent;
  int unsigned bytes_framed;
  int unsigned lines_checked;
  int unsigned lines_dropped;
  int unsigned failures;
  int unsigned cycles;

  // Idle control for the byte source and the result side
  bit          src_idle_on  = 1'b1;
  bit          sink_idle_on = 1'b1;
  int unsigned sink_hold;
  int unsigned sink_wait;

  function automatic void clear_line_model();
    fr_index      = '0;
    fr_xor        = '0;
    fr_comment    = 1'b0;
    fr_star_at    = '0;
    fr_star       = 1'b0;
    fr_after_star = 1'b0;
    fr_phase      = alfx_pkg::PHASE_BLANKS;
    fr_value      = '0;
    fr_bad_number = 1'b0;
    fr_text_len   = '0;
  endfunction

  // Advance the line state by one byte; queue a result at the terminator of a live line
  function automatic void frame_byte(input logic [alfx_pkg::DATA_W-1:0] c);
    line_result_t r;
    int unsigned  acc;
    logic         digit;
    digit = (c >= alfx_pkg::CHAR_ZERO) && (c <= alfx_pkg::CHAR_NINE);
    if (int'(fr_index) >= alfx_pkg::LINE_CAPACITY) begin
      fr_live  = 1'b0;
      fr_index = '0;
    end
    if (c == alfx_pkg::CHAR_CR || c == alfx_pkg::CHAR_LF || c == alfx_pkg::CHAR_BANG) begin
      if (fr_live) begin
        bytes_framed++;
        r.checksum = fr_xor;
        if (fr_star && fr_after_star) begin
          if ((fr_phase == alfx_pkg::PHASE_DIGITS || fr_phase == alfx_pkg::PHASE_DONE) &&
              !fr_bad_number && fr_value == {1'b0, fr_xor}) begin
            r.status = alfx_pkg::STATUS_GOOD;
            r.length = fr_star_at;
          end else begin
            r.status = alfx_pkg::STATUS_BAD;
            r.length = '0;
          end
        end else begin
          r.status = alfx_pkg::STATUS_PLAIN;
          r.length = (int'(fr_text_len) > alfx_pkg::CMD_LIMIT) ?
                     alfx_pkg::LEN_W'(alfx_pkg::CMD_LIMIT) : fr_text_len;
        end
        r.first_char = (r.length != 0) ? fr_head : '0;
        expected_lines.push_back(r);
      end else begin
        lines_dropped++;
      end
      clear_line_model();
      fr_live = 1'b1;
    end else if (fr_live) begin
      bytes_framed++;
      if (fr_index == 0) fr_head = c;
      if (!fr_comment) begin
        if (c == alfx_pkg::CHAR_SEMI) begin
          fr_comment = 1'b1;
        end else begin
          fr_text_len = fr_index + 1'b1;
          if (!fr_star) begin
            if (c == alfx_pkg::CHAR_STAR) begin
              fr_star    = 1'b1;
              fr_star_at = fr_index;
            end else begin
              fr_xor ^= c;
            end
          end else begin
            fr_after_star = 1'b1;
            // checksum number: blanks, optional plus, digits
            if (int'(fr_index) < alfx_pkg::CMD_LIMIT) begin
              case (fr_phase)
                alfx_pkg::PHASE_BLANKS: begin
                  if (c == alfx_pkg::CHAR_SPACE || c == alfx_pkg::CHAR_TAB ||
                      c == alfx_pkg::CHAR_VT || c == alfx_pkg::CHAR_FF) begin
                  end else if (c == alfx_pkg::CHAR_PLUS) begin
                    fr_phase = alfx_pkg::PHASE_SIGN;
                  end else if (digit) begin
                    fr_value = alfx_pkg::VAL_W'(c - alfx_pkg::CHAR_ZERO);
                    fr_phase = alfx_pkg::PHASE_DIGITS;
                  end else begin
                    fr_bad_number = 1'b1;
                    fr_phase      = alfx_pkg::PHASE_DONE;
                  end
                end
                alfx_pkg::PHASE_SIGN: begin
                  if (digit) begin
                    fr_value = alfx_pkg::VAL_W'(c - alfx_pkg::CHAR_ZERO);
                    fr_phase = alfx_pkg::PHASE_DIGITS;
                  end else begin
                    fr_bad_number = 1'b1;
                    fr_phase      = alfx_pkg::PHASE_DONE;
                  end
                end
                alfx_pkg::PHASE_DIGITS: begin
                  if (digit) begin
                    acc = int'(fr_value) * 10 + int'(c - alfx_pkg::CHAR_ZERO);
                    if (acc > alfx_pkg::VALUE_MAX) begin
                      fr_bad_number = 1'b1;
                      acc = alfx_pkg::VALUE_MAX + 1;
                    end
                    fr_value = alfx_pkg::VAL_W'(acc);
                  end else begin
                    fr_phase = alfx_pkg::PHASE_DONE;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
      end
      fr_index = fr_index + 1'b1;
    end
  endfunction

  // One input transaction, with a random gap ahead of it
  task automatic send_byte(input logic [alfx_pkg::DATA_W-1:0] c);
    int unsigned gap;
    gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= c;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    frame_byte(c);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_staged();
    foreach (staged[i]) send_byte(staged[i]);
    staged.delete();
  endtask

  // Sender pause until every queued line result is back
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_lines.size() != 0) @(posedge clk);
  endtask

  function automatic logic [alfx_pkg::DATA_W-1:0] text_xor(input string s);
    logic [alfx_pkg::DATA_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < s.len(); i++) sum ^= s[i];
    return sum;
  endfunction

  // Append n command bytes (no terminator, ';' or '*'); returns their XOR
  function automatic logic [alfx_pkg::DATA_W-1:0] stage_text(input int unsigned n);
    logic [alfx_pkg::DATA_W-1:0] c;
    logic [alfx_pkg::DATA_W-1:0] sum;
    sum = '0;
    repeat (n) begin
      do begin
        c = ($urandom_range(0, 3) == 0) ? alfx_pkg::DATA_W'($urandom_range(0, 255))
                                        : alfx_pkg::DATA_W'($urandom_range(32, 126));
      end while (c == alfx_pkg::CHAR_CR || c == alfx_pkg::CHAR_LF ||
                 c == alfx_pkg::CHAR_BANG || c == alfx_pkg::CHAR_SEMI ||
                 c == alfx_pkg::CHAR_STAR);
      staged.push_back(c);
      sum ^= c;
    end
    return sum;
  endfunction

  // Decimal digits of v, zero padded to at least width characters
  function automatic void stage_number(input int unsigned v, input int unsigned width);
    string digits;
    digits = $sformatf("%0d", v);
    while (digits.len() < width) digits = {"0", digits};
    for (int i = 0; i < digits.len(); i++) staged.push_back(digits[i]);
  endfunction

  function automatic logic [alfx_pkg::DATA_W-1:0] pick_terminator();
    case ($urandom_range(0, 2))
      0:       return alfx_pkg::CHAR_CR;
      1:       return alfx_pkg::CHAR_LF;
      default: return alfx_pkg::CHAR_BANG;
    endcase
  endfunction

  function automatic logic [alfx_pkg::DATA_W-1:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return alfx_pkg::CHAR_SPACE;
      1:       return alfx_pkg::CHAR_TAB;
      2:       return alfx_pkg::CHAR_VT;
      default: return alfx_pkg::CHAR_FF;
    endcase
  endfunction

  // Build one random line: mostly well formed, some broken or noise
  task automatic stage_random_line();
    line_kind_t                  kind;
    int unsigned                 pick;
    int unsigned                 n;
    logic [alfx_pkg::DATA_W-1:0] sum;
    pick = $urandom_range(0, 99);
    if (pick < 25)      kind = LINE_PLAIN;
    else if (pick < 60) kind = LINE_GOOD_SUM;
    else if (pick < 75) kind = LINE_BAD_SUM;
    else if (pick < 88) kind = LINE_MALFORMED;
    else                kind = LINE_NOISE;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
    case (kind)
      LINE_NOISE: begin
        repeat ($urandom_range(1, 16)) begin
          staged.push_back(alfx_pkg::DATA_W'($urandom_range(0, 255)));
        end
      end
      default: begin
        sum = stage_text(n);
        if (kind == LINE_PLAIN) begin
          // trailing star with nothing after it
          if ($urandom_range(0, 5) == 0) staged.push_back(alfx_pkg::CHAR_STAR);
        end else begin
          staged.push_back(alfx_pkg::CHAR_STAR);
          repeat ($urandom_range(0, 2)) staged.push_back(pick_blank());
          if (kind == LINE_MALFORMED) begin
            case ($urandom_range(0, 3))
              0: begin
                staged.push_back(CHAR_MINUS);
                stage_number(sum, 0);
              end
              1: begin
              end
              2: begin
                staged.push_back(alfx_pkg::CHAR_PLUS);
                staged.push_back(alfx_pkg::CHAR_SPACE);
              end
              default: staged.push_back(alfx_pkg::CHAR_STAR);
            endcase
          end else begin
            if ($urandom_range(0, 2) == 0) staged.push_back(alfx_pkg::CHAR_PLUS);
            if (kind == LINE_GOOD_SUM) begin
              stage_number(sum, ($urandom_range(0, 4) == 0) ? 3 : 0);
            end else if ($urandom_range(0, 3) == 0) begin
              stage_number($urandom_range(alfx_pkg::VALUE_MAX + 1, 999), 0);
            end else begin
              stage_number(sum ^ alfx_pkg::DATA_W'($urandom_range(1, 255)), 0);
            end
            // junk after the digits
            if ($urandom_range(0, 3) == 0) begin
              staged.push_back(alfx_pkg::CHAR_SPACE);
              void'(stage_text($urandom_range(1, 4)));
            end
          end
        end
        if ($urandom_range(0, 4) == 0) begin
          staged.push_back(alfx_pkg::CHAR_SEMI);
          void'(stage_text($urandom_range(0, 8)));
        end
      end
    endcase
    staged.push_back(pick_terminator());
  endtask

  // Result side: random ready stalls, plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      line_ch.ready <= 1'b0;
      sink_wait = 0;
    end else if (sink_hold != 0) begin
      sink_hold--;
      line_ch.ready <= 1'b0;
    end else if (line_ch.valid && line_ch.ready) begin
      sink_wait = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      line_ch.ready <= (sink_wait == 0);
    end else if (sink_wait != 0) begin
      sink_wait--;
      line_ch.ready <= (sink_wait == 0);
    end else begin
      line_ch.ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest expected line
  always @(posedge clk) begin : result_compare
    line_result_t want;
    if (!rst && line_ch.valid && line_ch.ready) begin
      lines_checked++;
      if (expected_lines.size() == 0) begin
        $error("unexpected line result: line_status %0d command_length %0d",
               line_ch.line_status, line_ch.command_length);
        failures++;
      end else begin
        want = expected_lines.pop_front();
        if (line_ch.line_status !== want.status) begin
          $error("line_status: expected %0d, got %0d", want.status, line_ch.line_status);
          failures++;
        end
        if (line_ch.command_length !== want.length) begin
          $error("command_length: expected %0d, got %0d", want.length,
                 line_ch.command_length);
          failures++;
        end
        if (line_ch.first_char !== want.first_char) begin
          $error("first_char: expected 0x%02h, got 0x%02h", want.first_char,
                 line_ch.first_char);
          failures++;
        end
        if (line_ch.computed_checksum !== want.checksum) begin
          $error("computed_checksum: expected 0x%02h, got 0x%02h", want.checksum,
                 line_ch.computed_checksum);
          failures++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Empty lines, every checksum form and each corner of the number parser
  task automatic test_directed_lines();
    string cmd;
    cmd = "M1 10";
    send_text("\r\n");
    send_text("A!");
    send_text({cmd, "*", $sformatf("%0d", text_xor(cmd)), "\n"});
    send_text({cmd, "*", $sformatf("%0d", text_xor(cmd) ^ 8'h01), "\r"});
    send_text("*\n");
    send_text("G*;note\n");
    send_text("X*-88\n");
    send_text("X*300\n");
    send_text("X*256\n");
    send_text("X*abc\n");
    send_text("X*+\n");
    send_text("X* \t+088;x\n");
    send_text("X*");
    send_byte(alfx_pkg::CHAR_VT);
    send_byte(alfx_pkg::CHAR_FF);
    send_text("88*7\n");
    send_text("X*88 junk!");
    send_text(";only comment\n");
    send_text("AB;C*5\n");
    send_text("*0\n");
    send_text("*  \n");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_text("\n");
    wait_drained();
  endtask

  // Lines at and beyond the store size
  task automatic test_line_capacity();
    logic [alfx_pkg::DATA_W-1:0] sum;
    // good checksum ending on the byte before the last kept one
    sum = stage_text(alfx_pkg::LINE_CAPACITY - 5);
    staged.push_back(alfx_pkg::CHAR_STAR);
    stage_number(sum, 3);
    staged.push_back(alfx_pkg::CHAR_LF);
    send_staged();
    // exactly full with a trailing star: dropped at the terminator
    void'(stage_text(alfx_pkg::LINE_CAPACITY - 1));
    staged.push_back(alfx_pkg::CHAR_STAR);
    staged.push_back(alfx_pkg::CHAR_BANG);
    send_staged();
    // past full, with a star and a comment ahead of the ignored bytes
    void'(stage_text(alfx_pkg::LINE_CAPACITY - 2));
    staged.push_back(alfx_pkg::CHAR_STAR);
    staged.push_back(alfx_pkg::CHAR_SEMI);
    void'(stage_text(4));
    staged.push_back(alfx_pkg::CHAR_LF);
    send_staged();
    send_text("OK\n");
    wait_drained();
  endtask

  // Receiver holds off while short lines keep coming, so the input stalls
  task automatic test_backpressure();
    src_idle_on = 1'b0;
    sink_hold   = HOLD_CYCLES;
    repeat (16) begin
      void'(stage_text($urandom_range(0, 3)));
      staged.push_back(pick_terminator());
      send_staged();
    end
    src_idle_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_lines();
    int unsigned start;
    start = bytes_framed;
    while (bytes_framed - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) src_idle_on = !src_idle_on;
      if ($urandom_range(0, 7) == 0) sink_idle_on = !sink_idle_on;
      if ($urandom_range(0, 39) == 0) wait_drained();
      stage_random_line();
      send_staged();
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  initial begin
    rst               <= 1'b1;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    clear_line_model();
    fr_live = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_lines();
    test_line_capacity();
    test_backpressure();
    test_random_lines();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d bytes framed, %0d line results checked, %0d overlong lines dropped",
             bytes_framed, lines_checked, lines_dropped);
    $display("tb: covered plain, good and bad checksums, comments, capacity and stalls");
    if (failures == 0 && expected_lines.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/alfx_pkg.sv
rtl/core/alfx_if.sv
rtl/core/alfx_ram.sv
rtl/core/alfx_parser.sv
rtl/core/alfx_result.sv
rtl/core/ascii_line_framer_xor_checksum_unit.sv
sim/ascii_line_framer_xor_checksum_unit_tb.sv
